[rtl/assert_macros.svh]
// Assertion macros used by the checker file of the execute unit.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define RVM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("execute unit check failed");

// Next-cycle implication, disabled while reset is asserted (active low).
`define RVM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("execute unit check failed");

`endif

[rtl/rvm_pkg.sv]
// Package of the register VM execute unit: field widths, opcodes, FSM states.
// Depends on nothing; used by the top level and the checker.
`default_nettype none

package rvm_pkg;

    localparam int MODE_W = 5;
    localparam int IDX_W  = 8;
    localparam int IP_W   = 12;
    localparam int WORD_W = 64;

    typedef enum logic [MODE_W-1:0] {
        MODE_NOOP      = 5'd0,
        MODE_SETWORD   = 5'd1,
        MODE_SETBOOL   = 5'd2,
        MODE_ADD       = 5'd3,
        MODE_GTE       = 5'd4,
        MODE_LT        = 5'd5,
        MODE_LTE       = 5'd6,
        MODE_GT        = 5'd7,
        MODE_EQ        = 5'd8,
        MODE_NE        = 5'd9,
        MODE_NOT       = 5'd10,
        MODE_OR        = 5'd11,
        MODE_AND       = 5'd12,
        MODE_COPY      = 5'd13,
        MODE_JUMP      = 5'd14,
        MODE_JUMPIF    = 5'd15,
        MODE_JUMPIFNOT = 5'd16
    } t_mode;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_EXEC
    } t_state;

endpackage

`default_nettype wire

[rtl/register_vm_execute_unit.sv]
// Register VM execute unit: one bytecode instruction per request.
// Path from request accept to result valid: register file read, operand capture, execute.
// A new request waits until the last one has passed the register file RAM read and the
// execute/write-back step, which holds while an older result is unclaimed; it is taken
// once write-back is done, even while the last result still waits in its register.
// Reset: program counter to zero, all register valid bits cleared (registers read zero).
`default_nettype none

module register_vm_execute_unit #(
    parameter int REG_COUNT     = 256,
    parameter int PROGRAM_DEPTH = 4096
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // request channel
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [rvm_pkg::MODE_W-1:0]         i_mode,
    input  logic [rvm_pkg::IDX_W-1:0]          i_left_index,
    input  logic [rvm_pkg::IDX_W-1:0]          i_right_index,
    input  logic [rvm_pkg::IDX_W-1:0]          i_target_index,
    input  logic signed [rvm_pkg::WORD_W-1:0]  i_immediate,
    input  logic [rvm_pkg::IP_W-1:0]           i_jump_target,
    // result channel
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [rvm_pkg::IP_W-1:0]           o_next_ip,
    output logic                               o_wrote,
    output logic [rvm_pkg::IDX_W-1:0]          o_written_index,
    output logic signed [rvm_pkg::WORD_W-1:0]  o_written_value
);

    import rvm_pkg::*;

    // Only the first 2**IDX_W registers can ever be addressed.
    localparam int RF_USED = (REG_COUNT < (1 << IDX_W)) ? REG_COUNT : (1 << IDX_W);
    localparam int AW      = $clog2(RF_USED);
    localparam int RF_SIZE = 1 << AW;

    // Jump target reduction modulo PROGRAM_DEPTH by reciprocal multiply.
    // With a 24-bit scale the quotient of a 12-bit target is exact for any
    // depth below 2**IP_W; at or above that the target is already in range.
    localparam int RECIP_SHIFT = 24;
    localparam longint unsigned RECIP_FULL =
        ((64'd1 << RECIP_SHIFT) + 64'(PROGRAM_DEPTH) - 64'd1) / 64'(PROGRAM_DEPTH);
    localparam logic [RECIP_SHIFT-1:0] JT_RECIP = RECIP_SHIFT'(RECIP_FULL);
    localparam bit JT_WRAP = (PROGRAM_DEPTH < (1 << IP_W));
    localparam int PROD_W  = IP_W + RECIP_SHIFT;

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    t_state               r_state, n_state;
    logic [IP_W-1:0]      r_pc, n_pc;
    logic [RF_SIZE-1:0]   r_valid;       // register written since reset
    logic                 r_out_valid;

    // Request fields, held for the whole instruction
    logic [MODE_W-1:0]    r_mode;
    logic [IDX_W-1:0]     r_li;
    logic [IDX_W-1:0]     r_ri;
    logic [IDX_W-1:0]     r_ti;
    logic [WORD_W-1:0]    r_imm;
    logic [IP_W-1:0]      r_jt;

    // Operands and jump quotient
    logic [WORD_W-1:0]    r_a;
    logic [WORD_W-1:0]    r_b;
    logic [IP_W-1:0]      r_quo;

    // Result register
    logic [IP_W-1:0]      r_next_ip;
    logic                 r_wrote;
    logic [IDX_W-1:0]     r_widx;
    logic [WORD_W-1:0]    r_wval;

    logic                 in_accept;
    logic                 exec_go;
    logic [WORD_W-1:0]    rdata_a;
    logic [WORD_W-1:0]    rdata_b;
    logic                 a_ok;
    logic                 b_ok;
    logic [PROD_W-1:0]    quo_prod;

    logic                 lt_ab;
    logic                 lt_ba;
    logic                 a_nz;
    logic                 b_nz;
    logic [IP_W:0]        ip_inc;
    logic [IP_W-1:0]      ip_seq;
    logic [IP_W-1:0]      jt_mod;
    logic                 wr_op;
    logic                 jump;
    logic                 do_write;
    logic [WORD_W-1:0]    res_val;

    assign in_accept  = i_in_valid && o_in_ready;
    // Execute only when the result register is free or being drained.
    assign exec_go    = (r_state == ST_EXEC) && (!r_out_valid || i_out_ready);

    // ------------------------------------------------------------------
    // Register file: two mirrored RAMs give two read ports.
    // Both are read at request accept and written at execute.
    // ------------------------------------------------------------------
    rvm_ram #(
        .WIDTH (WORD_W),
        .DEPTH (RF_SIZE)
    ) u_rf_a (
        .i_clk   (i_clk),
        .i_we    (do_write && exec_go),
        .i_waddr (r_ti[AW-1:0]),
        .i_wdata (res_val),
        .i_re    (in_accept),
        .i_raddr (i_left_index[AW-1:0]),
        .o_rdata (rdata_a)
    );

    rvm_ram #(
        .WIDTH (WORD_W),
        .DEPTH (RF_SIZE)
    ) u_rf_b (
        .i_clk   (i_clk),
        .i_we    (do_write && exec_go),
        .i_waddr (r_ti[AW-1:0]),
        .i_wdata (res_val),
        .i_re    (in_accept),
        .i_raddr (i_right_index[AW-1:0]),
        .o_rdata (rdata_b)
    );

    // ------------------------------------------------------------------
    // FSM: IDLE takes a request, READ captures operands, EXEC writes back.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                // refuse requests while reset is asserted
                o_in_ready = i_rst_n;
                if (i_in_valid) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                n_state = ST_EXEC;
            end
            ST_EXEC: begin
                // hold while the previous result is still unclaimed
                if (!r_out_valid || i_out_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Request capture
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_mode <= i_mode;
            r_li   <= i_left_index;
            r_ri   <= i_right_index;
            r_ti   <= i_target_index;
            r_imm  <= i_immediate;
            r_jt   <= i_jump_target;
        end
    end

    // ------------------------------------------------------------------
    // Operand stage: drop data of unwritten or out-of-range registers,
    // and form the jump quotient.
    // ------------------------------------------------------------------
    always_comb begin
        a_ok     = (32'(r_li) < REG_COUNT) && r_valid[r_li[AW-1:0]];
        b_ok     = (32'(r_ri) < REG_COUNT) && r_valid[r_ri[AW-1:0]];
        quo_prod = PROD_W'(r_jt) * PROD_W'(JT_RECIP);
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_READ) begin
            r_a   <= a_ok ? rdata_a : '0;
            r_b   <= b_ok ? rdata_b : '0;
            r_quo <= quo_prod[PROD_W-1:RECIP_SHIFT];
        end
    end

    // ------------------------------------------------------------------
    // Execute: ALU, next program counter, write decision
    // ------------------------------------------------------------------
    always_comb begin
        lt_ab  = $signed(r_a) < $signed(r_b);
        lt_ba  = $signed(r_b) < $signed(r_a);
        a_nz   = |r_a;
        b_nz   = |r_b;

        // sequential ip wraps at the program depth
        ip_inc = {1'b0, r_pc} + (IP_W+1)'(1);
        ip_seq = (32'(ip_inc) >= PROGRAM_DEPTH) ? '0 : ip_inc[IP_W-1:0];
        jt_mod = JT_WRAP ? (r_jt - IP_W'(32'(r_quo) * 32'(PROGRAM_DEPTH))) : r_jt;

        wr_op   = 1'b1;
        jump    = 1'b0;
        res_val = '0;
        case (r_mode)
            MODE_SETWORD:   res_val = r_imm;
            MODE_SETBOOL:   res_val = WORD_W'(r_imm[0]);
            MODE_ADD:       res_val = r_a + r_b;
            MODE_GTE:       res_val = WORD_W'(!lt_ab);
            MODE_LT:        res_val = WORD_W'(lt_ab);
            MODE_LTE:       res_val = WORD_W'(!lt_ba);
            MODE_GT:        res_val = WORD_W'(lt_ba);
            MODE_EQ:        res_val = WORD_W'(r_a == r_b);
            MODE_NE:        res_val = WORD_W'(r_a != r_b);
            MODE_NOT:       res_val = WORD_W'(!a_nz);
            MODE_OR:        res_val = WORD_W'(a_nz || b_nz);
            MODE_AND:       res_val = WORD_W'(a_nz && b_nz);
            MODE_COPY:      res_val = r_a;
            MODE_JUMP: begin
                wr_op = 1'b0;
                jump  = 1'b1;
            end
            MODE_JUMPIF: begin
                wr_op = 1'b0;
                jump  = a_nz;
            end
            MODE_JUMPIFNOT: begin
                wr_op = 1'b0;
                jump  = !a_nz;
            end
            default: begin
                // noop and unknown modes: advance only
                wr_op = 1'b0;
            end
        endcase

        // drop writes to registers that do not exist
        do_write = wr_op && (32'(r_ti) < REG_COUNT);
        n_pc     = jump ? jt_mod : ip_seq;
    end

    // ------------------------------------------------------------------
    // Architectural state and valid bits
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc    <= '0;
            r_valid <= '0;
        end else if (exec_go) begin
            r_pc <= n_pc;
            if (do_write) begin
                r_valid[r_ti[AW-1:0]] <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result register: load on execute, clear valid when taken.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (exec_go) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (exec_go) begin
            r_next_ip <= n_pc;
            r_wrote   <= do_write;
            r_widx    <= do_write ? r_ti : '0;
            r_wval    <= do_write ? res_val : '0;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_next_ip       = r_next_ip;
    assign o_wrote         = r_wrote;
    assign o_written_index = r_widx;
    assign o_written_value = r_wval;

endmodule

`default_nettype wire

[rtl/rvm_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`default_nettype none

module rvm_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

[rtl/rvm_checker.sv]
// Port-level checks of the register VM execute unit, bound to the top level.
// Depends on rvm_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module rvm_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    input  logic                               o_in_ready,
    input  logic                               o_out_valid,
    input  logic                               i_out_ready,
    input  logic [rvm_pkg::IP_W-1:0]           o_next_ip,
    input  logic                               o_wrote,
    input  logic [rvm_pkg::IDX_W-1:0]          o_written_index,
    input  logic signed [rvm_pkg::WORD_W-1:0]  o_written_value
);

    import rvm_pkg::*;

    logic in_acc;
    logic out_stall;

    assign in_acc    = i_in_valid && o_in_ready;
    assign out_stall = o_out_valid && !i_out_ready;

    // a stalled result holds
    `RVM_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_stall,
        o_out_valid && $stable(o_next_ip) && $stable(o_wrote) && $stable(o_written_value))

    // a result without a write carries zero index and value
    `RVM_ASSERT_NOW(a_nowrite_zero, i_clk, i_rst_n, o_out_valid && !o_wrote,
        o_written_index == '0 && o_written_value == '0)

    // one request in flight: ready drops right after an accept
    `RVM_ASSERT_NEXT(a_one_inflight, i_clk, i_rst_n, in_acc, !o_in_ready)

    // a fresh result follows its request accept through the read and execute states
    `RVM_ASSERT_NOW(a_latency, i_clk, i_rst_n, $rose(o_out_valid), $past(in_acc, 3))

endmodule

bind register_vm_execute_unit rvm_checker u_rvm_checker (.*);

`default_nettype wire

[tb/tb_register_vm_execute_unit.sv]
// Self-checking testbench of register_vm_execute_unit: directed and random instruction streams.
// Depends on rvm_pkg and the execute unit RTL; a built-in predictor keeps shadow registers and pc.
module tb_register_vm_execute_unit;

    import rvm_pkg::*;

    localparam int REG_COUNT     = 256;
    localparam int PROGRAM_DEPTH = 4096;
    localparam int RANDOM_ITEMS  = 1150;
    localparam int DRAIN_EVERY   = 250;   // hold the sender until drained at this spacing
    localparam int POOL_SIZE     = 6;     // registers one random program works on
    localparam int WATCHDOG_MAX  = 2000;  // cycles without any handshake before giving up
    localparam int TAIL_CYCLES   = 12;    // leave room for stray results
    localparam int MAX_PRINTS    = 40;
    localparam int MODE_LAST     = (1 << MODE_W) - 1;
    localparam int MODE_UNKNOWN  = MODE_JUMPIFNOT + 1;

    typedef logic [WORD_W-1:0] t_word;

    localparam t_word WORD_ONES = '1;
    localparam t_word WORD_MAX  = {1'b0, {(WORD_W-1){1'b1}}};
    localparam t_word WORD_MIN  = {1'b1, {(WORD_W-1){1'b0}}};
    localparam t_word WORD_ONE  = t_word'(1);
    localparam t_word FLOAT_ONE = t_word'(64'h3FF0_0000_0000_0000);

    typedef struct {
        logic [MODE_W-1:0] mode;
        logic [IDX_W-1:0]  left;
        logic [IDX_W-1:0]  right;
        logic [IDX_W-1:0]  target;
        t_word             imm;
        logic [IP_W-1:0]   jt;
        bit                wait_drain;
    } t_instr;

    typedef struct {
        logic [IP_W-1:0]  next_ip;
        logic             wrote;
        logic [IDX_W-1:0] widx;
        t_word            wval;
    } t_result;

    // Clock, reset and every block input start at known values.
    logic              i_clk          = 1'b0;
    logic              i_rst_n        = 1'b0;
    logic              in_valid       = 1'b0;
    logic [MODE_W-1:0] mode           = '0;
    logic [IDX_W-1:0]  left_index     = '0;
    logic [IDX_W-1:0]  right_index    = '0;
    logic [IDX_W-1:0]  target_index   = '0;
    t_word             immediate      = '0;
    logic [IP_W-1:0]   jump_target    = '0;
    logic              out_ready      = 1'b0;

    logic              o_in_ready;
    logic              o_out_valid;
    logic [IP_W-1:0]   o_next_ip;
    logic              o_wrote;
    logic [IDX_W-1:0]  o_written_index;
    t_word             o_written_value;

    // Shadow architectural state of the unit.
    t_word             shadow_regs [REG_COUNT];
    logic [IP_W-1:0]   shadow_pc;

    t_instr            pending_requests[$];
    t_instr            cur_request;
    t_result           result_by_seq[int];   // expected result, keyed by request sequence number
    int                issued_count  = 0;    // requests accepted (updated nonblocking)
    int                retired_count = 0;    // results accepted (updated nonblocking)
    int                total_requests = 0;
    int                fail_count    = 0;
    int                quiet_cycles  = 0;
    int                sender_idle_pct;
    int                receiver_idle_pct;
    logic              taken;
    logic              drained;
    t_result           want;

    register_vm_execute_unit #(
        .REG_COUNT     (REG_COUNT),
        .PROGRAM_DEPTH (PROGRAM_DEPTH)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (in_valid),
        .o_in_ready      (o_in_ready),
        .i_mode          (mode),
        .i_left_index    (left_index),
        .i_right_index   (right_index),
        .i_target_index  (target_index),
        .i_immediate     (immediate),
        .i_jump_target   (jump_target),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (out_ready),
        .o_next_ip       (o_next_ip),
        .o_wrote         (o_wrote),
        .o_written_index (o_written_index),
        .o_written_value (o_written_value)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Idle profile by progress: receiver-light first, sender-light next, then full rate.
    always @* begin
        if (issued_count < total_requests / 3) begin
            sender_idle_pct   = 25;
            receiver_idle_pct = 51;
        end else if (issued_count < (2 * total_requests) / 3) begin
            sender_idle_pct   = 51;
            receiver_idle_pct = 25;
        end else begin
            sender_idle_pct   = 0;
            receiver_idle_pct = 0;
        end
    end

    // Run one instruction on the shadow state and return the result it must produce.
    function automatic t_result execute_instr(t_instr ins);
        t_word           a;
        t_word           b;
        t_word           val;
        logic [IP_W-1:0] next_pc;
        logic            writes;
        t_result         res;
        // Sources beyond the register file read as zero.
        a = (int'(ins.left) < REG_COUNT) ? shadow_regs[ins.left] : '0;
        b = (int'(ins.right) < REG_COUNT) ? shadow_regs[ins.right] : '0;
        // PROGRAM_DEPTH equals 2**IP_W, so the 12-bit sum wraps as required.
        next_pc = shadow_pc + 1'b1;
        writes  = 1'b1;
        val     = '0;
        case (ins.mode)
            MODE_SETWORD:   val = ins.imm;
            MODE_SETBOOL:   val = t_word'(ins.imm[0]);
            MODE_ADD:       val = a + b;
            MODE_GTE:       val = t_word'($signed(a) >= $signed(b));
            MODE_LT:        val = t_word'($signed(a) < $signed(b));
            MODE_LTE:       val = t_word'($signed(a) <= $signed(b));
            MODE_GT:        val = t_word'($signed(a) > $signed(b));
            MODE_EQ:        val = t_word'(a == b);
            MODE_NE:        val = t_word'(a != b);
            MODE_NOT:       val = t_word'(a == '0);
            MODE_OR:        val = t_word'((a != '0) || (b != '0));
            MODE_AND:       val = t_word'((a != '0) && (b != '0));
            MODE_COPY:      val = a;
            MODE_JUMP: begin
                writes  = 1'b0;
                next_pc = ins.jt;
            end
            MODE_JUMPIF: begin
                writes = 1'b0;
                if (a != '0) next_pc = ins.jt;
            end
            MODE_JUMPIFNOT: begin
                writes = 1'b0;
                if (a == '0) next_pc = ins.jt;
            end
            default:        writes = 1'b0;   // noop and unknown modes
        endcase
        // Drop writes aimed past the register file.
        if (writes && int'(ins.target) >= REG_COUNT) writes = 1'b0;
        if (writes) shadow_regs[ins.target] = val;
        shadow_pc   = next_pc;
        res.next_ip = next_pc;
        res.wrote   = writes;
        res.widx    = writes ? ins.target : '0;
        res.wval    = writes ? val : '0;
        return res;
    endfunction

    function automatic t_instr make_instr(logic [MODE_W-1:0] m, logic [IDX_W-1:0] l,
                                          logic [IDX_W-1:0] r, logic [IDX_W-1:0] t,
                                          t_word imm, logic [IP_W-1:0] jt);
        t_instr x;
        x.mode       = m;
        x.left       = l;
        x.right      = r;
        x.target     = t;
        x.imm        = imm;
        x.jt         = jt;
        x.wait_drain = 1'b0;
        return x;
    endfunction

    // Append a request; every DRAIN_EVERY-th one waits until all results are back.
    function automatic void queue_request(t_instr x);
        x.wait_drain = (pending_requests.size() > 0) &&
                       (pending_requests.size() % DRAIN_EVERY == 0);
        pending_requests.insert(pending_requests.size(), x);
    endfunction

    // Pick a word biased toward the signed extremes and small values.
    function automatic t_word pick_word();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return WORD_ONE;
            2:       return WORD_ONES;
            3:       return WORD_MIN;
            4:       return WORD_MAX;
            5:       return t_word'($urandom_range(0, 20)) - t_word'(10);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Mostly registers of the current pool, so operands carry written values.
    function automatic logic [IDX_W-1:0] pool_reg(logic [IDX_W-1:0] base);
        if ($urandom_range(0, 9) == 0) return IDX_W'($urandom);
        return base + IDX_W'($urandom_range(0, POOL_SIZE - 1));
    endfunction

    function automatic logic [IP_W-1:0] pick_target();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return IP_W'(PROGRAM_DEPTH - 1 - $urandom_range(0, 3));
            default: return IP_W'($urandom);
        endcase
    endfunction

    // Build a short program: seed the pool, then operate on it and branch.
    task automatic add_program();
        logic [IDX_W-1:0]  base;
        logic [MODE_W-1:0] m;
        int                len;
        base = IDX_W'($urandom);
        len  = $urandom_range(4, 12);
        for (int k = 0; k < len; k++) begin
            if (k < 2) m = MODE_SETWORD;
            else m = MODE_W'($urandom_range(MODE_SETWORD, MODE_JUMPIFNOT));
            queue_request(make_instr(m, pool_reg(base), pool_reg(base), pool_reg(base),
                                     ($urandom_range(0, 1) == 0) ? pick_word()
                                                                  : {$urandom, $urandom},
                                     pick_target()));
        end
    endtask

    // Driver: present queued requests, hold each one until it is taken.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            taken = in_valid && o_in_ready;
            if (taken) begin
                result_by_seq[issued_count] = execute_instr(cur_request);
                issued_count <= issued_count + 1;
            end
            drained = (issued_count + (taken ? 1 : 0)) == retired_count;
            if (!in_valid || taken) begin
                if (pending_requests.size() > 0 &&
                    $urandom_range(0, 99) >= sender_idle_pct &&
                    (!pending_requests[0].wait_drain || drained)) begin
                    cur_request = pending_requests.pop_front();
                    in_valid     <= 1'b1;
                    mode         <= cur_request.mode;
                    left_index   <= cur_request.left;
                    right_index  <= cur_request.right;
                    target_index <= cur_request.target;
                    immediate    <= cur_request.imm;
                    jump_target  <= cur_request.jt;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    task automatic report_mismatch(string what);
        fail_count++;
        if (fail_count <= MAX_PRINTS) $display("[%0t] mismatch: %s", $time, what);
    endtask

    // Monitor: compare each accepted result with the oldest expectation.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (o_out_valid && out_ready) begin
                if (retired_count == issued_count) begin
                    report_mismatch("result with no request outstanding");
                end else begin
                    want = result_by_seq[retired_count];
                    result_by_seq.delete(retired_count);
                    if (o_next_ip !== want.next_ip)
                        report_mismatch($sformatf("result %0d next_ip got %0d want %0d",
                                                  retired_count, o_next_ip, want.next_ip));
                    if (o_wrote !== want.wrote)
                        report_mismatch($sformatf("result %0d wrote got %0b want %0b",
                                                  retired_count, o_wrote, want.wrote));
                    if (o_written_index !== want.widx)
                        report_mismatch($sformatf("result %0d written_index got %0d want %0d",
                                                  retired_count, o_written_index, want.widx));
                    if (o_written_value !== want.wval)
                        report_mismatch($sformatf("result %0d written_value got %h want %h",
                                                  retired_count, o_written_value, want.wval));
                    retired_count <= retired_count + 1;
                end
            end
            out_ready <= $urandom_range(0, 99) >= receiver_idle_pct;
        end
    end

    // Watchdog: stop when neither channel moves for too long.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((in_valid && o_in_ready) || (o_out_valid && out_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= WATCHDOG_MAX) begin
                $display("CHECKS FAILED");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial begin
        foreach (shadow_regs[i]) shadow_regs[i] = '0;
        shadow_pc = '0;

        // Directed: signed extremes, float bits, booleans, every operation.
        queue_request(make_instr(MODE_SETWORD, 0, 0, 1, WORD_MAX, 0));
        queue_request(make_instr(MODE_SETWORD, 0, 0, 2, WORD_MIN, 0));
        queue_request(make_instr(MODE_SETWORD, 0, 0, 3, WORD_ONES, 0));
        queue_request(make_instr(MODE_SETWORD, 0, 0, 4, FLOAT_ONE, 0));
        queue_request(make_instr(MODE_SETBOOL, 0, 0, 5, WORD_ONES, 0));
        queue_request(make_instr(MODE_SETBOOL, 0, 0, 6, WORD_ONES - WORD_ONE, 0));
        queue_request(make_instr(MODE_ADD, 1, 3, 7, '0, 0));
        queue_request(make_instr(MODE_ADD, 1, 1, 8, '0, 0));      // overflow wraps
        queue_request(make_instr(MODE_GTE, 2, 1, 9, '0, 0));
        queue_request(make_instr(MODE_LT, 2, 1, 10, '0, 0));
        queue_request(make_instr(MODE_LTE, 1, 1, 11, '0, 0));
        queue_request(make_instr(MODE_GT, 1, 2, 12, '0, 0));
        queue_request(make_instr(MODE_EQ, 3, 3, 13, '0, 0));
        queue_request(make_instr(MODE_NE, 3, 0, 14, '0, 0));
        queue_request(make_instr(MODE_NOT, 0, 0, 15, '0, 0));
        queue_request(make_instr(MODE_OR, 0, 0, 16, '0, 0));
        queue_request(make_instr(MODE_AND, 5, 3, 17, '0, 0));
        queue_request(make_instr(MODE_COPY, 2, 0, '1, '0, 0));
        // Jump to the last address, then let the pc wrap with an all-ones noop.
        queue_request(make_instr(MODE_JUMP, 0, 0, 0, '0, '1));
        queue_request(make_instr(MODE_NOOP, '1, '1, '1, WORD_ONES, '1));
        queue_request(make_instr(MODE_W'(MODE_LAST), '1, '1, '1, WORD_ONES, '1));
        queue_request(make_instr(MODE_W'(MODE_UNKNOWN), 3, 3, 20, WORD_ONES, 7));
        queue_request(make_instr(MODE_JUMPIF, 0, 0, 0, '0, 100));
        queue_request(make_instr(MODE_JUMPIF, 3, 0, 0, '0, '1));
        queue_request(make_instr(MODE_JUMPIFNOT, 0, 0, 0, '0, 0));

        // Random: mostly well-formed programs, some raw noise over all modes.
        while (pending_requests.size() < RANDOM_ITEMS) begin
            if ($urandom_range(0, 99) < 85) begin
                add_program();
            end else begin
                queue_request(make_instr(MODE_W'($urandom_range(0, MODE_LAST)),
                                         IDX_W'($urandom), IDX_W'($urandom), IDX_W'($urandom),
                                         {$urandom, $urandom}, IP_W'($urandom)));
            end
        end
        total_requests = pending_requests.size();

        // Hold reset at the start, then release it for good.
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Sample at the falling edge so the clocked blocks have settled.
        do @(negedge i_clk);
        while (pending_requests.size() != 0 || in_valid || issued_count != retired_count);
        repeat (TAIL_CYCLES) @(negedge i_clk);

        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
